### rtl/eeb_pkg.sv
// Shared constants and controller/datapath interface types for the Bezout core.
package eeb_pkg;

  localparam int DEF_DATA_WIDTH = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new request and seed the coefficients
    logic start;    // set up one Euclid round: magnitudes, signs, step count
    logic step;     // one restoring-division step plus one Horner step
    logic finish;   // close the round: rotate remainders and coefficients
    logic publish;  // copy the finished result into the output register
  } eeb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic b_zero;     // current divisor operand is zero, loop ends
    logic last_step;  // division counter is on its final step
  } eeb_status_t;

endpackage

### rtl/eeb_ctrl.sv
// Sequencing state machine for the extended Euclid core.
module eeb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  eeb_pkg::eeb_status_t status,
  output eeb_pkg::eeb_cmd_t    cmd
);
  import eeb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.start   = (state == ST_CHECK) && !status.b_zero;
    cmd.step    = (state == ST_DIV);
    cmd.finish  = (state == ST_UPDATE);
    cmd.publish = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken; a new one overrides the drop.
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= status.b_zero ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (status.last_step) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_CHECK;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/eeb_dpath.sv
// Datapath: operand and coefficient registers, serial divider, Horner products.
module eeb_dpath #(
  parameter int DATA_WIDTH = eeb_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] first_value,
  input  logic signed [DATA_WIDTH-1:0] second_value,
  input  eeb_pkg::eeb_cmd_t            cmd,
  output eeb_pkg::eeb_status_t         status,
  output logic signed [DATA_WIDTH-1:0] divisor,
  output logic signed [DATA_WIDTH-1:0] coeff_first,
  output logic signed [DATA_WIDTH-1:0] coeff_second
);
  import eeb_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] a, b, xa, ya, xb, yb;
  logic [DATA_WIDTH-1:0] quo, rem, md, px, py;
  logic                  qneg, aneg;
  logic [CNT_W-1:0]      count;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   shifted, diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_next, px_next, py_next;
  logic [DATA_WIDTH-1:0] r_signed, nx, ny;

  assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

  // Restoring division step; quotient bits come out MSB first
  assign shifted  = {rem, quo[DATA_WIDTH-1]};
  assign diff     = shifted - {1'b0, md};
  assign qbit     = !diff[DATA_WIDTH];
  assign rem_next = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];

  // Horner accumulation of |q| * xb and |q| * yb, modulo 2^DATA_WIDTH
  assign px_next = {px[DATA_WIDTH-2:0], 1'b0} + (qbit ? xb : '0);
  assign py_next = {py[DATA_WIDTH-2:0], 1'b0} + (qbit ? yb : '0);

  // Remainder takes the dividend's sign; q*x is subtracted with q's sign
  assign r_signed = aneg ? (~rem + 1'b1) : rem;
  assign nx       = qneg ? (xa + px) : (xa - px);
  assign ny       = qneg ? (ya + py) : (ya - py);

  assign status.b_zero    = (b == '0);
  assign status.last_step = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start) begin
      count <= LAST_CNT;
    end else if (cmd.step && count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a  <= first_value;
      b  <= second_value;
      xa <= DATA_WIDTH'(1);
      ya <= '0;
      xb <= '0;
      yb <= DATA_WIDTH'(1);
    end
    if (cmd.start) begin
      quo  <= mag_a;
      md   <= mag_b;
      rem  <= '0;
      px   <= '0;
      py   <= '0;
      qneg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      aneg <= a[DATA_WIDTH-1];
    end
    if (cmd.step) begin
      quo <= {quo[DATA_WIDTH-2:0], qbit};
      rem <= rem_next;
      px  <= px_next;
      py  <= py_next;
    end
    if (cmd.finish) begin
      a  <= b;
      b  <= r_signed;
      xa <= xb;
      ya <= yb;
      xb <= nx;
      yb <= ny;
    end
    if (cmd.publish) begin
      divisor      <= a;
      coeff_first  <= xa;
      coeff_second <= ya;
    end
  end

endmodule

### rtl/extended_euclid_bezout_core.sv
// From request accept to result valid the core runs R Euclid rounds (R up to ~46 at 32 bits).
// Each round is a setup state, DATA_WIDTH restoring division steps with both coefficient
// products built alongside, and an update state.
// Requests: one in flight at a time; the next is taken once the result sits in the output
// register, so only an older result still stalled there holds it off.
// Reset: synchronous, active high; clears the sequencer, the step counter and output valid.
module extended_euclid_bezout_core #(
  parameter int DATA_WIDTH = eeb_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] first_value,
  input  logic signed [DATA_WIDTH-1:0] second_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] divisor,
  output logic signed [DATA_WIDTH-1:0] coeff_first,
  output logic signed [DATA_WIDTH-1:0] coeff_second
);
  import eeb_pkg::*;

  eeb_cmd_t    cmd;
  eeb_status_t status;

  // Controller: walks CHECK -> DIV (DATA_WIDTH steps) -> UPDATE per round,
  // leaves the loop when the remainder operand hits zero, then hands the
  // result to the output register as soon as that register is free.
  eeb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: truncating signed division on magnitudes with sign fix-up,
  // coefficient update x' = x_prev - q*x computed modulo 2^DATA_WIDTH.
  eeb_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .first_value  (first_value),
    .second_value (second_value),
    .cmd          (cmd),
    .status       (status),
    .divisor      (divisor),
    .coeff_first  (coeff_first),
    .coeff_second (coeff_second)
  );

endmodule

### rtl/eeb_checker.sv
// Port-level checks for the Bezout core and their binding to the top level.
module eeb_checker #(
  parameter int DATA_WIDTH = eeb_pkg::DEF_DATA_WIDTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [DATA_WIDTH-1:0] first_value,
  input logic signed [DATA_WIDTH-1:0] second_value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] divisor,
  input logic signed [DATA_WIDTH-1:0] coeff_first,
  input logic signed [DATA_WIDTH-1:0] coeff_second
);

  // Hold a stalled request steady
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(first_value) &&
      $stable(second_value))
    else $error("stalled request changed");

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(divisor) &&
      $stable(coeff_first) && $stable(coeff_second))
    else $error("stalled result changed");

  // Block further requests while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A new result only ends a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

endmodule

bind extended_euclid_bezout_core eeb_checker #(.DATA_WIDTH(DATA_WIDTH)) u_eeb_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the extended Euclid / Bezout coefficient core.
`timescale 1ns / 1ps

module testbench;

  localparam int W = eeb_pkg::DEF_DATA_WIDTH;
  // Cycles with no request or result moving before the run is called hung.
  // The worst case is about 46 Euclid rounds plus a stall burst; allow several times that.
  localparam int HANG_LIMIT = 10000;
  localparam int NUM_RANDOM = 400;
  // The last stretch of random requests runs with no idling on either side.
  localparam int QUIET_FROM = 340;

  typedef logic [W-1:0] word_t;

  localparam word_t MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    word_t g;
    word_t x;
    word_t y;
  } bezout_t;

  // Predicts the Bezout triple for each request and checks results in order.
  class bezout_scoreboard;
    bezout_t pending[$];
    int mismatches;
    int requests;
    int results;
    int rounds_total;
    int rounds_max;

    function new();
      mismatches = 0;
      requests = 0;
      results = 0;
      rounds_total = 0;
      rounds_max = 0;
    endfunction

    // Signed division rounding toward zero; remainder follows the dividend.
    function void trunc_divide(input word_t num, input word_t den,
                               output word_t quo, output word_t rem);
      word_t mag_num;
      word_t mag_den;
      word_t q_mag;
      word_t r_mag;
      mag_num = num[W-1] ? word_t'(0) - num : num;
      mag_den = den[W-1] ? word_t'(0) - den : den;
      q_mag = mag_num / mag_den;
      r_mag = mag_num % mag_den;
      quo = (num[W-1] != den[W-1]) ? word_t'(0) - q_mag : q_mag;
      rem = num[W-1] ? word_t'(0) - r_mag : r_mag;
    endfunction

    function void note_request(input word_t a_in, input word_t b_in);
      word_t a, b, xa, ya, xb, yb, q, r, nx, ny;
      int rounds;
      bezout_t triple;
      a = a_in;
      b = b_in;
      xa = 1;
      ya = 0;
      xb = 0;
      yb = 1;
      rounds = 0;
      while (b != 0) begin
        trunc_divide(a, b, q, r);
        a = b;
        b = r;
        nx = xa - q * xb;
        ny = ya - q * yb;
        xa = xb;
        ya = yb;
        xb = nx;
        yb = ny;
        rounds++;
      end
      triple.g = a;
      triple.x = xa;
      triple.y = ya;
      pending.push_back(triple);
      requests++;
      rounds_total += rounds;
      if (rounds > rounds_max) rounds_max = rounds;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(input word_t g, input word_t x, input word_t y);
      bezout_t want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result (%0d, %0d, %0d) with no request outstanding",
                         $signed(g), $signed(x), $signed(y)));
      end else begin
        want = pending.pop_front();
        if (g !== want.g)
          report($sformatf("divisor got %0d expected %0d", $signed(g), $signed(want.g)));
        if (x !== want.x)
          report($sformatf("coeff_first got %0d expected %0d",
                           $signed(x), $signed(want.x)));
        if (y !== want.y)
          report($sformatf("coeff_second got %0d expected %0d",
                           $signed(y), $signed(want.y)));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [W-1:0] first_value;
  logic signed [W-1:0] second_value;
  logic out_valid;
  logic out_stall;
  logic signed [W-1:0] divisor;
  logic signed [W-1:0] coeff_first;
  logic signed [W-1:0] coeff_second;

  // Set for the tail of the run: both sides stop idling.
  logic quiet;
  int hang_count;

  bezout_scoreboard sb;

  extended_euclid_bezout_core #(
    .DATA_WIDTH(W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_value  (first_value),
    .second_value (second_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .divisor      (divisor),
    .coeff_first  (coeff_first),
    .coeff_second (coeff_second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result taken on the output channel. All values here are read
  // right after the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(divisor, coeff_first, coeff_second);
  end

  // Hang detector: count edges where neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("No request or result moved for %0d cycles", HANG_LIMIT);
      $display("extended_euclid_bezout_core verification failed");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // Result-side backpressure: random stall bursts of random length with
  // open stretches of varying length between them; drop stalls once quiet.
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
        // Sometimes leave a long open stretch so results flow back to back.
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 200)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until the core takes it, then record it.
  task automatic send_request(input word_t a, input word_t b);
    in_valid <= 1'b1;
    first_value <= a;
    second_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(a, b);
  endtask

  // Optionally drop valid for a burst before the next request.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic word_t random_sign(input word_t v);
    return ($urandom_range(0, 1) == 1) ? word_t'(0) - v : v;
  endfunction

  // Full-width random word inside the legal operand range.
  function automatic word_t random_word();
    word_t v;
    v = word_t'({$urandom(), $urandom()});
    if (v == MOST_NEG) v = MAX_POS;
    return v;
  endfunction

  // Build an operand pair of one of several shapes: raw random, small values,
  // a shared factor, consecutive Fibonacci numbers (longest Euclid chains),
  // or a degenerate pair (zero, equal, one dividing the other).
  task automatic random_pair(output word_t a, output word_t b);
    word_t k, f0, f1, f2;
    int n;
    case ($urandom_range(0, 7))
      0, 1: begin
        a = random_word();
        b = random_word();
      end
      2: begin
        a = random_sign(word_t'($urandom_range(0, 300)));
        b = random_sign(word_t'($urandom_range(0, 300)));
      end
      3, 4: begin
        k = word_t'($urandom_range(1, 5000));
        a = random_sign(k * word_t'($urandom_range(0, 100000)));
        b = random_sign(k * word_t'($urandom_range(1, 100000)));
      end
      5: begin
        n = $urandom_range(1, 45);
        f0 = 0;
        f1 = 1;
        repeat (n) begin
          f2 = f0 + f1;
          f0 = f1;
          f1 = f2;
        end
        a = random_sign(f1);
        b = random_sign(f0);
        if ($urandom_range(0, 3) == 0) begin
          f2 = a;
          a = b;
          b = f2;
        end
      end
      default: begin
        a = random_word();
        case ($urandom_range(0, 3))
          0: b = 0;
          1: b = random_sign(a);
          2: begin
            b = a;
            a = 0;
          end
          default: begin
            b = random_sign(word_t'($urandom_range(1, 1000)));
            a = b * word_t'($urandom_range(0, 1000000));
          end
        endcase
      end
    endcase
  endtask

  initial begin
    // Directed pairs: zeros, sign combinations, extremes, the longest chain at
    // this width, and the out-of-range most negative value where wrap applies.
    word_t dir_a[24] = '{
      word_t'(0), word_t'(5), -word_t'(5), word_t'(0), word_t'(0),
      MAX_POS, MAX_POS, -MAX_POS, MAX_POS, word_t'(1),
      word_t'(1836311903), -word_t'(1836311903), word_t'(240), -word_t'(240),
      word_t'(240), -word_t'(240), MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
      -word_t'(1), MOST_NEG, -MAX_POS, word_t'(32'h5555_5555)
    };
    word_t dir_b[24] = '{
      word_t'(0), word_t'(0), word_t'(0), word_t'(7), -word_t'(7),
      MAX_POS, -MAX_POS, MAX_POS, word_t'(1), MAX_POS,
      word_t'(1134903170), word_t'(1134903170), word_t'(46), word_t'(46),
      -word_t'(46), -word_t'(46), -word_t'(1), word_t'(1), MOST_NEG, word_t'(0),
      MOST_NEG, word_t'(6), -MAX_POS + 1, word_t'(32'hAAAA_AAAA)
    };
    word_t a;
    word_t b;
    int i;

    sb = new();
    quiet = 1'b0;
    in_valid = 1'b0;
    first_value = '0;
    second_value = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 24; i++) begin
      maybe_idle();
      send_request(dir_a[i], dir_b[i]);
    end

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      maybe_idle();
      random_pair(a, b);
      send_request(a, b);
    end
    in_valid <= 1'b0;

    // Drain, then hold a few round times to catch any stray result.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * (W + 2)) @(posedge clk);

    $display("Sent %0d requests (%0d directed), %0d Euclid rounds in all, longest %0d",
             sb.requests, 24, sb.rounds_total, sb.rounds_max);
    $display("Checked %0d results, %0d mismatches, %0d still outstanding",
             sb.results, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("extended_euclid_bezout_core verification clean");
    end else begin
      $display("extended_euclid_bezout_core verification failed");
    end
    $finish;
  end

endmodule
